@@ rtl/lcvm_pkg.sv @@
package lcvm_pkg;

  localparam int CoordBits = 16;
  localparam int NumRegs   = 8;
  localparam int RegIdxBits = 3;
  localparam int ProdBits  = 2 * (CoordBits + 1);
  localparam int QuotBits  = ProdBits;
  localparam int SumBits   = QuotBits + 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0]   diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [SumBits-1:0]   sum_t;

  localparam logic [3:0] OC_TOP    = 4'd8;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_LEFT   = 4'd1;

  localparam logic [RegIdxBits-1:0] REG_WIN_LEFT    = 3'd0;
  localparam logic [RegIdxBits-1:0] REG_WIN_BOTTOM  = 3'd1;
  localparam logic [RegIdxBits-1:0] REG_WIN_RIGHT   = 3'd2;
  localparam logic [RegIdxBits-1:0] REG_WIN_TOP     = 3'd3;
  localparam logic [RegIdxBits-1:0] REG_VIEW_LEFT   = 3'd4;
  localparam logic [RegIdxBits-1:0] REG_VIEW_BOTTOM = 3'd5;
  localparam logic [RegIdxBits-1:0] REG_VIEW_RIGHT  = 3'd6;
  localparam logic [RegIdxBits-1:0] REG_VIEW_TOP    = 3'd7;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_CLIP  = 3'd2;
  localparam logic [2:0] OP_CLIPW = 3'd3;
  localparam logic [2:0] OP_MAP   = 3'd4;
  localparam logic [2:0] OP_MAPW  = 3'd5;
  localparam logic [2:0] OP_DONE  = 3'd6;

  typedef struct packed {
    logic       load;
    logic       clip_start;
    logic       clip_write;
    logic       map_start;
    logic [1:0] map_sel;
    logic       map_write;
    logic       accept;
    logic       reject;
  } cmd_t;

  typedef struct packed {
    logic trivial_accept;
    logic trivial_reject;
    logic div_done;
  } status_t;

  function automatic coord_t sat(input sum_t v);
    sum_t mx;
    sum_t mn;
    mx = sum_t'((1 <<< (CoordBits - 1)) - 1);
    mn = -mx - sum_t'(1);
    if (v > mx) return coord_t'(mx);
    if (v < mn) return coord_t'(mn);
    return coord_t'(v);
  endfunction

  function automatic logic [3:0] outcode(input coord_t x, input coord_t y, input coord_t wl,
                                         input coord_t wb, input coord_t wr, input coord_t wt);
    logic [3:0] c;
    c = 4'd0;
    if (y > wt) c = c | OC_TOP;
    else if (y < wb) c = c | OC_BOTTOM;
    if (x > wr) c = c | OC_RIGHT;
    else if (x < wl) c = c | OC_LEFT;
    return c;
  endfunction

endpackage

@@ rtl/lcvm_seg_if.sv @@
interface lcvm_seg_if;
  logic   valid;
  logic   ready;
  lcvm_pkg::coord_t start_x;
  lcvm_pkg::coord_t start_y;
  lcvm_pkg::coord_t end_x;
  lcvm_pkg::coord_t end_y;
  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ rtl/lcvm_res_if.sv @@
interface lcvm_res_if;
  logic   valid;
  logic   ready;
  logic   visible;
  lcvm_pkg::coord_t out_start_x;
  lcvm_pkg::coord_t out_start_y;
  lcvm_pkg::coord_t out_end_x;
  lcvm_pkg::coord_t out_end_y;
  modport source(output valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                 input ready);
  modport sink(input valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
               output ready);
endinterface

@@ rtl/lcvm_muldiv.sv @@
// a*b/c, truncate toward zero, 0 if c is zero; restoring divider, one bit a cycle
module lcvm_muldiv (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lcvm_pkg::diff_t       a,
  input  lcvm_pkg::diff_t       b,
  input  lcvm_pkg::diff_t       c,
  output logic                  done,
  output lcvm_pkg::prod_t       quot
);
  localparam int PB = lcvm_pkg::ProdBits;
  localparam int CB = lcvm_pkg::CoordBits + 1;
  localparam int CntBits = $clog2(PB + 2);

  logic [PB-1:0]    num;
  logic [CB-1:0]    den;
  logic [CB:0]      rem;
  logic [PB-1:0]    q;
  logic             neg;
  logic             zero;
  logic             busy;
  logic             mul_pend;
  logic [CntBits-1:0] cnt;
  logic [CB-1:0]    ma;
  logic [CB-1:0]    mb;
  logic [CB:0]      rem_sh;

  assign rem_sh = {rem[CB-1:0], num[PB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mul_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma <= a[CB-1] ? CB'(-a) : CB'(a);
        mb <= b[CB-1] ? CB'(-b) : CB'(b);
        den <= c[CB-1] ? CB'(-c) : CB'(c);
        neg <= (a[CB-1] ^ b[CB-1]) ^ c[CB-1];
        zero <= (c == '0);
        mul_pend <= 1'b1;
      end else if (mul_pend) begin
        num <= PB'(ma) * PB'(mb);
        rem <= '0;
        q <= '0;
        cnt <= CntBits'(PB);
        mul_pend <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (zero) quot <= '0;
          else quot <= neg ? -q : q;
        end else begin
          cnt <= cnt - 1'b1;
          num <= num << 1;
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            q <= {q[PB-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q <= {q[PB-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

@@ rtl/lcvm_datapath.sv @@
module lcvm_datapath (
  input  logic                         clk,
  input  lcvm_pkg::cmd_t               cmd,
  output lcvm_pkg::status_t            status,
  input  logic                         rst,
  input  lcvm_pkg::coord_t             in_x0,
  input  lcvm_pkg::coord_t             in_y0,
  input  lcvm_pkg::coord_t             in_x1,
  input  lcvm_pkg::coord_t             in_y1,
  input  lcvm_pkg::coord_t             regs [lcvm_pkg::NumRegs],
  output logic                         visible,
  output lcvm_pkg::coord_t             res [4]
);
  lcvm_pkg::coord_t x0, y0, x1, y1;
  logic [3:0] c0, c1, co;
  lcvm_pkg::coord_t wl, wb, wr, wt;
  lcvm_pkg::diff_t da, db, dc;
  lcvm_pkg::prod_t quot;
  logic div_done;
  lcvm_pkg::coord_t p, wmin, wmax, vmin, vmax, nx, ny;
  lcvm_pkg::sum_t base;

  assign wl = regs[lcvm_pkg::REG_WIN_LEFT];
  assign wb = regs[lcvm_pkg::REG_WIN_BOTTOM];
  assign wr = regs[lcvm_pkg::REG_WIN_RIGHT];
  assign wt = regs[lcvm_pkg::REG_WIN_TOP];

  assign c0 = lcvm_pkg::outcode(x0, y0, wl, wb, wr, wt);
  assign c1 = lcvm_pkg::outcode(x1, y1, wl, wb, wr, wt);
  assign co = (c0 != 4'd0) ? c0 : c1;
  assign status.trivial_accept = ((c0 | c1) == 4'd0);
  assign status.trivial_reject = ((c0 & c1) != 4'd0);
  assign status.div_done = div_done;

  always_comb begin
    p = x0;
    wmin = wl;
    wmax = wr;
    vmin = regs[lcvm_pkg::REG_VIEW_LEFT];
    vmax = regs[lcvm_pkg::REG_VIEW_RIGHT];
    case (cmd.map_sel)
      2'd1: begin
        p = y0; wmin = wb; wmax = wt;
        vmin = regs[lcvm_pkg::REG_VIEW_BOTTOM]; vmax = regs[lcvm_pkg::REG_VIEW_TOP];
      end
      2'd2: p = x1;
      2'd3: begin
        p = y1; wmin = wb; wmax = wt;
        vmin = regs[lcvm_pkg::REG_VIEW_BOTTOM]; vmax = regs[lcvm_pkg::REG_VIEW_TOP];
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.map_start) begin
      da = lcvm_pkg::diff_t'(p) - lcvm_pkg::diff_t'(wmin);
      db = lcvm_pkg::diff_t'(vmax) - lcvm_pkg::diff_t'(vmin);
      dc = lcvm_pkg::diff_t'(wmax) - lcvm_pkg::diff_t'(wmin);
    end else if ((co & lcvm_pkg::OC_TOP) != 4'd0) begin
      da = lcvm_pkg::diff_t'(x1) - lcvm_pkg::diff_t'(x0);
      db = lcvm_pkg::diff_t'(wt) - lcvm_pkg::diff_t'(y0);
      dc = lcvm_pkg::diff_t'(y1) - lcvm_pkg::diff_t'(y0);
    end else if ((co & lcvm_pkg::OC_BOTTOM) != 4'd0) begin
      da = lcvm_pkg::diff_t'(x1) - lcvm_pkg::diff_t'(x0);
      db = lcvm_pkg::diff_t'(wb) - lcvm_pkg::diff_t'(y0);
      dc = lcvm_pkg::diff_t'(y1) - lcvm_pkg::diff_t'(y0);
    end else if ((co & lcvm_pkg::OC_RIGHT) != 4'd0) begin
      da = lcvm_pkg::diff_t'(y1) - lcvm_pkg::diff_t'(y0);
      db = lcvm_pkg::diff_t'(wr) - lcvm_pkg::diff_t'(x0);
      dc = lcvm_pkg::diff_t'(x1) - lcvm_pkg::diff_t'(x0);
    end else begin
      da = lcvm_pkg::diff_t'(y1) - lcvm_pkg::diff_t'(y0);
      db = lcvm_pkg::diff_t'(wl) - lcvm_pkg::diff_t'(x0);
      dc = lcvm_pkg::diff_t'(x1) - lcvm_pkg::diff_t'(x0);
    end
  end

  lcvm_muldiv u_div (
    .clk(clk), .rst(rst), .start(cmd.clip_start | cmd.map_start),
    .a(da), .b(db), .c(dc), .done(div_done), .quot(quot)
  );

  // quotient magnitude stays below 2^34, so the 2^35 limit of sum_t never binds
  always_comb begin
    if ((co & (lcvm_pkg::OC_TOP | lcvm_pkg::OC_BOTTOM)) != 4'd0) begin
      nx = lcvm_pkg::sat(lcvm_pkg::sum_t'(x0) + lcvm_pkg::sum_t'(quot));
      ny = ((co & lcvm_pkg::OC_TOP) != 4'd0) ? wt : wb;
    end else begin
      ny = lcvm_pkg::sat(lcvm_pkg::sum_t'(y0) + lcvm_pkg::sum_t'(quot));
      nx = ((co & lcvm_pkg::OC_RIGHT) != 4'd0) ? wr : wl;
    end
  end

  assign base = lcvm_pkg::sum_t'(vmin) + lcvm_pkg::sum_t'(quot);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= in_x0; y0 <= in_y0; x1 <= in_x1; y1 <= in_y1;
      visible <= 1'b0;
    end
    if (cmd.clip_write) begin
      if (co == c0) begin
        x0 <= nx; y0 <= ny;
      end else begin
        x1 <= nx; y1 <= ny;
      end
    end
    if (cmd.map_write) res[cmd.map_sel] <= lcvm_pkg::sat(base);
    if (cmd.accept) visible <= 1'b1;
    if (cmd.reject) begin
      visible <= 1'b0;
      res[0] <= '0; res[1] <= '0; res[2] <= '0; res[3] <= '0;
    end
  end
endmodule

@@ rtl/lcvm_ctrl.sv @@
module lcvm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_fire,
  input  lcvm_pkg::status_t  status,
  output lcvm_pkg::cmd_t     cmd,
  output logic               idle,
  output logic               res_valid
);
  logic [2:0] state, state_next;
  logic [2:0] steps;
  logic [1:0] sel;

  always_comb begin
    cmd = '0;
    cmd.map_sel = sel;
    state_next = state;
    unique case (state)
      lcvm_pkg::OP_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_next = lcvm_pkg::OP_CLIP;
      end
      lcvm_pkg::OP_CLIP: begin
        if (status.trivial_accept) begin
          cmd.accept = 1'b1;
          cmd.map_start = 1'b1;
          state_next = lcvm_pkg::OP_MAPW;
        end else if (status.trivial_reject || steps == 3'd4) begin
          cmd.reject = 1'b1;
          state_next = lcvm_pkg::OP_DONE;
        end else begin
          cmd.clip_start = 1'b1;
          state_next = lcvm_pkg::OP_CLIPW;
        end
      end
      lcvm_pkg::OP_CLIPW: if (status.div_done) begin
        cmd.clip_write = 1'b1;
        state_next = lcvm_pkg::OP_CLIP;
      end
      lcvm_pkg::OP_MAP: begin
        cmd.map_start = 1'b1;
        state_next = lcvm_pkg::OP_MAPW;
      end
      lcvm_pkg::OP_MAPW: if (status.div_done) begin
        cmd.map_write = 1'b1;
        state_next = (sel == 2'd3) ? lcvm_pkg::OP_DONE : lcvm_pkg::OP_MAP;
      end
      lcvm_pkg::OP_DONE: if (out_fire) state_next = lcvm_pkg::OP_IDLE;
      default: state_next = lcvm_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcvm_pkg::OP_IDLE;
      steps <= 3'd0;
      sel <= 2'd0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        steps <= 3'd0;
        sel <= 2'd0;
      end
      if (cmd.clip_start) steps <= steps + 3'd1;
      if (cmd.map_write) sel <= sel + 2'd1;
    end
  end

  assign idle = (state == lcvm_pkg::OP_IDLE);
  assign res_valid = (state == lcvm_pkg::OP_DONE);

  a_steps: assert property (@(posedge clk) disable iff (rst) steps <= 3'd4)
    else $error("clip step count overran");
  a_load: assert property (@(posedge clk) disable iff (rst) in_fire |-> idle)
    else $error("item taken while busy");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_fire) |=> res_valid) else $error("result dropped");
endmodule

@@ rtl/line_clip_viewport_map_core.sv @@
// channel  | dir | handshake    | payload
// seg      | in  | valid/ready  | start_x start_y end_x end_y
// res      | out | valid/ready  | visible out_start_x out_start_y out_end_x out_end_y
// cfg      | in  | cfg_we       | cfg_index cfg_data
// One item at a time; a shared serial multiply-divide unit runs each division as
// issue, multiply, one restoring step per bit of the 34-bit quotient, write. Up to
// four clip divisions and four map divisions per item; a trivial reject needs none.
// Synchronous active-high reset restores register defaults.
// The result holds until taken; the next item is accepted only after that.
module line_clip_viewport_map_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [lcvm_pkg::RegIdxBits-1:0]        cfg_index,
  input  logic [lcvm_pkg::CoordBits-1:0]         cfg_data,
  lcvm_seg_if.sink                               seg,
  lcvm_res_if.source                             res
);
  lcvm_pkg::coord_t regs [lcvm_pkg::NumRegs];
  lcvm_pkg::coord_t rvals [4];
  lcvm_pkg::cmd_t cmd;
  lcvm_pkg::status_t status;
  logic idle;
  logic in_fire;
  logic out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[lcvm_pkg::REG_WIN_LEFT]    <= 16'sd1600;
      regs[lcvm_pkg::REG_WIN_BOTTOM]  <= 16'sd1600;
      regs[lcvm_pkg::REG_WIN_RIGHT]   <= 16'sd2400;
      regs[lcvm_pkg::REG_WIN_TOP]     <= 16'sd2400;
      regs[lcvm_pkg::REG_VIEW_LEFT]   <= 16'sd3200;
      regs[lcvm_pkg::REG_VIEW_BOTTOM] <= 16'sd3200;
      regs[lcvm_pkg::REG_VIEW_RIGHT]  <= 16'sd4800;
      regs[lcvm_pkg::REG_VIEW_TOP]    <= 16'sd4800;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  assign seg.ready = idle;
  assign in_fire = seg.valid & idle;
  assign out_fire = res.valid & res.ready;

  lcvm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .status(status), .cmd(cmd), .idle(idle), .res_valid(res.valid)
  );

  lcvm_datapath u_dp (
    .clk(clk), .cmd(cmd), .status(status), .rst(rst),
    .in_x0(seg.start_x), .in_y0(seg.start_y), .in_x1(seg.end_x), .in_y1(seg.end_y),
    .regs(regs), .visible(res.visible), .res(rvals)
  );

  assign res.out_start_x = rvals[0];
  assign res.out_start_y = rvals[1];
  assign res.out_end_x   = rvals[2];
  assign res.out_end_y   = rvals[3];
endmodule
